@@ hw/rtl/jse_pkg.sv @@
// Package: beat types, escape unit kinds and byte tables for the JSON string escaper.
`default_nettype none

package jse_pkg;

    localparam int unsigned MARK_LEN = 14;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       string_last;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       string_end;
        logic       is_marker;
    } t_out_beat;

    typedef enum logic [1:0] {
        K_PLAIN = 2'd0,   // byte passes through
        K_SHORT = 2'd1,   // backslash + one letter
        K_UNI   = 2'd2,   // \u00XX
        K_MARK  = 2'd3    // truncation marker
    } t_kind;

    // One escape unit handed from the budget logic to the byte emitter.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] char_byte;
        logic       last;
    } t_unit;

    localparam logic [7:0] CH_BSLASH = 8'h5C;

    function automatic t_kind classify(input logic [7:0] b);
        t_kind k;
        k = K_PLAIN;
        case (b) inside
            8'h22, 8'h5C, 8'h08, 8'h0C, 8'h0A, 8'h0D, 8'h09: k = K_SHORT;
            [8'h00:8'h1F]:                                  k = K_UNI;
            default:                                        k = K_PLAIN;
        endcase
        return k;
    endfunction

    function automatic logic [3:0] unit_len(input t_kind k);
        logic [3:0] n;
        case (k)
            K_PLAIN: n = 4'd1;
            K_SHORT: n = 4'd2;
            K_UNI:   n = 4'd6;
            K_MARK:  n = 4'(MARK_LEN);
            default: n = 4'd1;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] short_letter(input logic [7:0] b);
        logic [7:0] c;
        case (b)
            8'h22:   c = 8'h22;  // "
            8'h5C:   c = 8'h5C;  // backslash
            8'h08:   c = 8'h62;  // b
            8'h0C:   c = 8'h66;  // f
            8'h0A:   c = 8'h6E;  // n
            8'h0D:   c = 8'h72;  // r
            8'h09:   c = 8'h74;  // t
            default: c = b;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = 8'h30 + {4'd0, d};
        end else begin
            c = 8'h57 + {4'd0, d};   // 'a' - 10
        end
        return c;
    endfunction

    // "...(truncated)"
    function automatic logic [7:0] mark_byte(input logic [3:0] i);
        logic [7:0] c;
        case (i)
            4'd0, 4'd1, 4'd2: c = 8'h2E;
            4'd3:    c = 8'h28;
            4'd4:    c = 8'h74;
            4'd5:    c = 8'h72;
            4'd6:    c = 8'h75;
            4'd7:    c = 8'h6E;
            4'd8:    c = 8'h63;
            4'd9:    c = 8'h61;
            4'd10:   c = 8'h74;
            4'd11:   c = 8'h65;
            4'd12:   c = 8'h64;
            4'd13:   c = 8'h29;
            default: c = 8'h29;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] unit_byte(input t_kind k, input logic [7:0] b,
                                             input logic [3:0] i);
        logic [7:0] c;
        c = b;
        case (k)
            K_PLAIN: c = b;
            K_SHORT: c = (i == 4'd0) ? CH_BSLASH : short_letter(b);
            K_UNI: begin
                case (i)
                    4'd0:    c = CH_BSLASH;
                    4'd1:    c = 8'h75;  // u
                    4'd2:    c = 8'h30;
                    4'd3:    c = 8'h30;
                    4'd4:    c = hex_digit(b[7:4]);
                    default: c = hex_digit(b[3:0]);
                endcase
            end
            K_MARK:  c = mark_byte(i);
            default: c = b;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/jse_emit.sv @@
// Byte emitter: holds one escape unit and streams its bytes into an output register.
`default_nettype none

module jse_emit
    import jse_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_unit_valid,
    output logic           o_unit_ready,
    input  wire t_unit     i_unit,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_beat      o_out_data
);

    logic       r_busy;
    t_unit      r_unit;
    logic [3:0] r_idx;
    logic       r_out_valid;
    t_out_beat  r_out;

    logic       w_advance;
    logic       w_last_byte;
    logic       w_move;
    t_out_beat  n_out;

    assign w_advance    = !r_out_valid || i_out_ready;
    assign w_last_byte  = (r_idx == unit_len(r_unit.kind) - 4'd1);
    assign w_move       = r_busy && w_advance;
    assign o_unit_ready = !r_busy || (w_advance && w_last_byte);

    always_comb begin
        n_out.out_byte   = unit_byte(r_unit.kind, r_unit.char_byte, r_idx);
        n_out.run_end    = w_last_byte;
        n_out.string_end = w_last_byte && r_unit.last;
        n_out.is_marker  = (r_unit.kind == K_MARK);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_unit_valid && o_unit_ready) begin
                r_busy <= 1'b1;
                r_unit <= i_unit;
                r_idx  <= '0;
            end else if (w_move && w_last_byte) begin
                r_busy <= 1'b0;
            end else if (w_move) begin
                r_idx <= r_idx + 4'd1;
            end
            if (w_advance) begin
                r_out_valid <= r_busy;
                r_out       <= n_out;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

@@ hw/rtl/json_string_escape_capped.sv @@
// Top level: JSON string escaper with an optional per-string escaped-byte budget.
//
// Input channel (i_in_valid / o_in_ready / i_in_data): one raw string byte per
// beat, string_last set on the final byte of a string.
// Output channel (o_out_valid / i_out_ready / o_out_data): one escaped byte per
// beat; run_end marks the last byte made from an input beat, string_end the
// last byte of a string, is_marker the bytes of "...(truncated)".
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
// index 0 = cap_enable, index 1 = escaped_cap; always ready, other indexes
// are ignored.
// Path: a taken input beat is registered as an escape unit in the emitter, and
// each of its bytes is then registered in the output register. Throughput: one
// output byte per cycle unless the receiver stalls. An input beat occupies the
// emitter for as many bytes as its escape unit is long (1 for plain text,
// 2 for short escapes, 6 for \u00XX, 14 for the marker), so plain text streams
// at one beat per cycle when unstalled; dropped beats skip the emitter.
// Budget check is done at input accept (one 17-bit add and compare).
// Reset: synchronous active low; budget enabled at 512 bytes, count cleared,
// no truncation in progress, output register empty.
// Receiver stall: the output register holds its beat; the emitter keeps its
// unit, and o_in_ready drops once the unit buffer is full.
`default_nettype none

module json_string_escape_capped
    import jse_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_beat    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_beat        o_out_data,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    localparam logic [7:0] REG_CAP_ENABLE = 8'd0;
    localparam logic [7:0] REG_ESC_CAP    = 8'd1;

    // config registers
    logic        r_cap_en;
    logic [15:0] r_cap;
    // per-string state
    logic [15:0] r_count;
    logic        r_dropping;

    logic        w_in_acc;
    t_kind       w_kind;
    logic [16:0] w_total;
    logic        w_over;
    logic        w_unit_ready;
    t_unit       w_unit;
    logic [15:0] n_count;
    logic        n_dropping;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = w_unit_ready;
    assign w_in_acc    = i_in_valid && o_in_ready;

    // Budget check: does this unit fit into what is left of the cap?
    assign w_kind  = classify(i_in_data.char_byte);
    assign w_total = {1'b0, r_count} + {13'd0, unit_len(w_kind)};
    assign w_over  = r_cap_en && (w_total > {1'b0, r_cap});

    always_comb begin
        w_unit.kind      = w_over ? K_MARK : w_kind;
        w_unit.char_byte = i_in_data.char_byte;
        w_unit.last      = i_in_data.string_last;
    end

    // Next per-string state; count saturates while the budget is off.
    always_comb begin
        n_count    = r_count;
        n_dropping = r_dropping;
        if (!r_dropping) begin
            if (w_over) begin
                n_dropping = 1'b1;
            end else begin
                n_count = w_total[16] ? 16'hFFFF : w_total[15:0];
            end
        end
        if (i_in_data.string_last) begin
            n_count    = '0;
            n_dropping = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_en   <= 1'b1;
            r_cap      <= 16'd512;
            r_count    <= '0;
            r_dropping <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_CAP_ENABLE) begin
                    r_cap_en <= i_cfg_data[0];
                end else if (i_cfg_index == REG_ESC_CAP) begin
                    r_cap <= i_cfg_data;
                end
            end
            if (w_in_acc) begin
                r_count    <= n_count;
                r_dropping <= n_dropping;
            end
        end
    end

    // Dropped beats are taken but never reach the emitter.
    jse_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_unit_valid (i_in_valid && !r_dropping),
        .o_unit_ready (w_unit_ready),
        .i_unit       (w_unit),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

    // End of string always clears the per-string state.
    a_string_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_data.string_last) |=> (r_count == 16'd0 && !r_dropping))
        else $error("per-string state not cleared at string end");

    // A unit that overflows the budget starts dropping.
    a_over_drops : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !r_dropping && w_over && !i_in_data.string_last) |=> r_dropping)
        else $error("overflowing unit did not start truncation");

    // string_end can only mark the final byte of a run.
    a_end_in_run : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.string_end) |-> o_out_data.run_end)
        else $error("string_end without run_end");

endmodule

`default_nettype wire

@@ verif/json_string_escape_capped_test.sv @@
// Testbench for the capped JSON string escaper: directed and random strings, scoreboard check.
`default_nettype none

module json_string_escape_capped_test;

    import jse_pkg::t_in_beat;
    import jse_pkg::t_out_beat;

    // Register map of the config channel.
    localparam logic [7:0] REG_CAP_ENABLE  = 8'd0;
    localparam logic [7:0] REG_ESCAPED_CAP = 8'd1;
    localparam logic [7:0] REG_UNMAPPED    = 8'd7;   // not decoded, write must be ignored

    localparam logic [15:0] DEFAULT_CAP = 16'd512;

    // Bytes that get a two-byte escape.
    localparam logic [7:0] BYTE_QUOTE  = 8'h22;
    localparam logic [7:0] BYTE_BSLASH = 8'h5C;
    localparam logic [7:0] BYTE_BS     = 8'h08;
    localparam logic [7:0] BYTE_FF     = 8'h0C;
    localparam logic [7:0] BYTE_LF     = 8'h0A;
    localparam logic [7:0] BYTE_CR     = 8'h0D;
    localparam logic [7:0] BYTE_TAB    = 8'h09;

    localparam logic [127:0]  HEX_TEXT   = "0123456789abcdef";
    localparam int            TRUNC_LEN  = 14;
    localparam logic [111:0]  TRUNC_TEXT = "...(truncated)";

    localparam int QUIET_CYCLES = 24;      // idle cycles after the last result before a reg write
    localparam int HOLD_CYCLES  = 80;      // long receiver hold-off
    localparam int CALM_TAIL    = 40;      // no idling once this few actions remain
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_BEATS  = 30;

    typedef enum logic [1:0] {
        ACT_BEAT,    // one input beat
        ACT_CFG,     // one register write
        ACT_DRAIN,   // wait until every expected byte is out, then a quiet stretch
        ACT_HOLD     // ask the receiver for a long hold-off
    } t_act_kind;

    typedef struct {
        t_act_kind   kind;
        t_in_beat    beat;
        logic [7:0]  reg_idx;
        logic [15:0] reg_val;
    } t_action;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        in_valid    = 1'b0;
    t_in_beat    in_data     = '0;
    logic        out_ready   = 1'b0;
    logic        cfg_valid   = 1'b0;
    logic [7:0]  cfg_index   = '0;
    logic [15:0] cfg_data    = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    t_out_beat   o_out_data;
    logic        o_cfg_ready;

    t_action   pending_q[$];     // stimulus still to be driven
    t_out_beat escaped_q[$];     // escaped bytes the block still owes us

    // Shadow of the block's registers and per-string state.
    logic        cap_on;
    logic [15:0] cap_bytes;
    logic [15:0] kept_count;
    logic        trunc_active;

    int   fail_count    = 0;
    int   beats_taken   = 0;
    int   bytes_checked = 0;
    int   markers_seen  = 0;
    int   strings_taken = 0;
    int   reg_writes    = 0;
    int   cycle_count   = 0;
    int   hold_req      = 0;
    int   gap_left      = 0;
    int   quiet_left    = 0;
    int   random_beats  = 0;
    logic calm          = 1'b0;
    logic run_done      = 1'b0;

    json_string_escape_capped uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Stimulus builders
    // ---------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b, input logic is_final);
        t_action act;
        act.kind                = ACT_BEAT;
        act.beat.char_byte      = b;
        act.beat.string_last    = is_final;
        act.reg_idx             = '0;
        act.reg_val             = '0;
        pending_q = {pending_q, act};
        random_beats++;
    endtask

    task automatic push_ctrl(input t_act_kind kind);
        t_action act;
        act.kind    = kind;
        act.beat    = '0;
        act.reg_idx = '0;
        act.reg_val = '0;
        pending_q = {pending_q, act};
    endtask

    // Register writes only go out once the block has gone quiet.
    task automatic push_cfg(input logic [7:0] idx, input logic [15:0] val);
        t_action act;
        push_ctrl(ACT_DRAIN);
        act.kind    = ACT_CFG;
        act.beat    = '0;
        act.reg_idx = idx;
        act.reg_val = val;
        pending_q = {pending_q, act};
    endtask

    task automatic set_budget(input logic enable, input logic [15:0] cap);
        push_cfg(REG_CAP_ENABLE, {15'd0, enable});
        push_cfg(REG_ESCAPED_CAP, cap);
    endtask

    // Mostly printable text, with escapes, control bytes, high bytes and raw noise mixed in.
    function automatic logic [7:0] pick_byte();
        int         r;
        logic [7:0] b;
        r = $urandom_range(0, 11);
        if (r == 0) begin
            case ($urandom_range(0, 6))
                0:       b = BYTE_QUOTE;
                1:       b = BYTE_BSLASH;
                2:       b = BYTE_BS;
                3:       b = BYTE_FF;
                4:       b = BYTE_LF;
                5:       b = BYTE_CR;
                default: b = BYTE_TAB;
            endcase
        end else if (r == 1) begin
            b = 8'($urandom_range(0, 31));
        end else if (r == 2) begin
            b = 8'($urandom_range(128, 255));
        end else if (r == 3) begin
            b = 8'($urandom_range(0, 255));
        end else begin
            b = 8'($urandom_range(32, 126));
        end
        return b;
    endfunction

    task automatic push_string(input int len);
        for (int i = 0; i < len; i++) begin
            push_byte(pick_byte(), i == len - 1);
        end
    endtask

    // ---------------------------------------------------------------
    // Driver: feeds input beats and register writes from pending_q.
    // Payload changes only when the previous beat was taken.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : driver
        t_action act;
        logic    next_in_valid;
        logic    next_cfg_valid;
        logic    stalled;
        if (!i_rst_n) begin
            in_valid   <= 1'b0;
            cfg_valid  <= 1'b0;
            gap_left   = 0;
            quiet_left = 0;
        end else begin
            stalled = (in_valid && !o_in_ready) || (cfg_valid && !o_cfg_ready);
            calm    = pending_q.size() < CALM_TAIL;
            if (!stalled) begin
                next_in_valid  = 1'b0;
                next_cfg_valid = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (quiet_left > 0) begin
                    // Count the quiet stretch only once nothing is owed any more.
                    if (escaped_q.size() == 0) begin
                        quiet_left--;
                    end
                end else if (pending_q.size() > 0) begin
                    act = pending_q.pop_front();
                    case (act.kind)
                        ACT_BEAT: begin
                            next_in_valid = 1'b1;
                            in_data       <= act.beat;
                            if (!calm && $urandom_range(0, 4) == 0) begin
                                gap_left = $urandom_range(1, 4);
                            end
                        end
                        ACT_CFG: begin
                            next_cfg_valid = 1'b1;
                            cfg_index      <= act.reg_idx;
                            cfg_data       <= act.reg_val;
                        end
                        ACT_DRAIN: begin
                            quiet_left = QUIET_CYCLES;
                        end
                        default: begin
                            hold_req++;
                        end
                    endcase
                end else begin
                    run_done = 1'b1;
                end
                in_valid  <= next_in_valid;
                cfg_valid <= next_cfg_valid;
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver: short random stalls, plus one long hold-off on request.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : receiver
        int hold_seen;
        int hold_left;
        int stall_left;
        if (!i_rst_n) begin
            out_ready  <= 1'b0;
            hold_seen  = 0;
            hold_left  = 0;
            stall_left = 0;
        end else begin
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 3);
                out_ready  <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: checks output beats against escaped_q, then escapes each
    // accepted input beat into escaped_q and tracks register writes.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        logic [7:0]  unit_q[$];
        logic [7:0]  esc_letter;
        logic [7:0]  b;
        logic [16:0] total;
        logic        mark;
        t_out_beat   got;
        t_out_beat   exp_beat;
        if (!i_rst_n) begin
            cap_on       = 1'b1;
            cap_bytes    = DEFAULT_CAP;
            kept_count   = '0;
            trunc_active = 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                got = o_out_data;
                if (escaped_q.size() == 0) begin
                    $error("unexpected output beat: out_byte %h", got.out_byte);
                    fail_count++;
                end else begin
                    exp_beat = escaped_q.pop_front();
                    bytes_checked++;
                    if (got.out_byte !== exp_beat.out_byte) begin
                        $error("out_byte: expected %h, got %h", exp_beat.out_byte, got.out_byte);
                        fail_count++;
                    end
                    if (got.run_end !== exp_beat.run_end) begin
                        $error("run_end: expected %b, got %b", exp_beat.run_end, got.run_end);
                        fail_count++;
                    end
                    if (got.string_end !== exp_beat.string_end) begin
                        $error("string_end: expected %b, got %b",
                               exp_beat.string_end, got.string_end);
                        fail_count++;
                    end
                    if (got.is_marker !== exp_beat.is_marker) begin
                        $error("is_marker: expected %b, got %b",
                               exp_beat.is_marker, got.is_marker);
                        fail_count++;
                    end
                    if (exp_beat.is_marker && exp_beat.run_end) begin
                        markers_seen++;
                    end
                end
            end

            if (cfg_valid && o_cfg_ready) begin
                reg_writes++;
                if (cfg_index == REG_CAP_ENABLE) begin
                    cap_on = cfg_data[0];
                end else if (cfg_index == REG_ESCAPED_CAP) begin
                    cap_bytes = cfg_data;
                end
            end

            if (in_valid && o_in_ready) begin
                beats_taken++;
                unit_q.delete();
                mark = 1'b0;
                b    = in_data.char_byte;
                if (!trunc_active) begin
                    case (b)
                        BYTE_QUOTE:  esc_letter = BYTE_QUOTE;
                        BYTE_BSLASH: esc_letter = BYTE_BSLASH;
                        BYTE_BS:     esc_letter = "b";
                        BYTE_FF:     esc_letter = "f";
                        BYTE_LF:     esc_letter = "n";
                        BYTE_CR:     esc_letter = "r";
                        BYTE_TAB:    esc_letter = "t";
                        default:     esc_letter = 8'h00;
                    endcase
                    if (esc_letter != 8'h00) begin
                        unit_q = {unit_q, BYTE_BSLASH};
                        unit_q = {unit_q, esc_letter};
                    end else if (b < 8'h20) begin
                        // \u00XX with lower-case hex
                        unit_q = {unit_q, BYTE_BSLASH};
                        unit_q = {unit_q, 8'h75};   // u
                        unit_q = {unit_q, 8'h30};   // 0
                        unit_q = {unit_q, 8'h30};   // 0
                        unit_q = {unit_q, HEX_TEXT[8 * (15 - int'(b[7:4])) +: 8]};
                        unit_q = {unit_q, HEX_TEXT[8 * (15 - int'(b[3:0])) +: 8]};
                    end else begin
                        unit_q = {unit_q, b};
                    end
                    total = {1'b0, kept_count} + 17'(unit_q.size());
                    if (cap_on && total > {1'b0, cap_bytes}) begin
                        // Unit does not fit: the whole marker goes out instead.
                        unit_q.delete();
                        for (int k = 0; k < TRUNC_LEN; k++) begin
                            unit_q = {unit_q, TRUNC_TEXT[8 * (TRUNC_LEN - 1 - k) +: 8]};
                        end
                        mark         = 1'b1;
                        trunc_active = 1'b1;
                    end else begin
                        // Counting goes on with the budget off, saturating.
                        kept_count = (total > 17'h0FFFF) ? 16'hFFFF : total[15:0];
                    end
                end
                for (int k = 0; k < unit_q.size(); k++) begin
                    exp_beat.out_byte   = unit_q[k];
                    exp_beat.run_end    = (k == unit_q.size() - 1);
                    exp_beat.string_end = exp_beat.run_end & in_data.string_last;
                    exp_beat.is_marker  = mark;
                    escaped_q = {escaped_q, exp_beat};
                end
                if (in_data.string_last) begin
                    strings_taken++;
                    kept_count   = '0;
                    trunc_active = 1'b0;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus plan, reset and final verdict
    // ---------------------------------------------------------------
    initial begin
        // Every escape kind plus both ends of the byte range, at the reset budget.
        push_byte(BYTE_QUOTE, 1'b0);
        push_byte(BYTE_BSLASH, 1'b0);
        push_byte(BYTE_BS, 1'b0);
        push_byte(BYTE_FF, 1'b0);
        push_byte(BYTE_LF, 1'b0);
        push_byte(BYTE_CR, 1'b0);
        push_byte(BYTE_TAB, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h1F, 1'b0);
        push_byte(8'h7E, 1'b0);
        push_byte(8'hFF, 1'b1);

        // Zero budget: marker on the first byte, then the final byte is dropped
        // and no beat of this string carries string_end.
        set_budget(1'b1, 16'd0);
        push_byte("x", 1'b0);
        push_byte("y", 1'b1);

        // A unit that lands exactly on the budget fits; the next one becomes
        // the marker, which then closes the string.
        set_budget(1'b1, 16'd3);
        push_byte("a", 1'b0);
        push_byte(BYTE_QUOTE, 1'b0);
        push_byte("b", 1'b1);

        // Budget smaller than the marker, overrun by a six-byte escape.
        set_budget(1'b1, 16'd5);
        push_byte("a", 1'b0);
        push_byte(8'h01, 1'b1);

        push_cfg(REG_UNMAPPED, 16'hFFFF);

        // Count runs with the budget off, then the budget is switched on in
        // mid-string, and switched off again while dropping.
        set_budget(1'b0, 16'd2);
        push_byte("a", 1'b0);
        push_byte("b", 1'b0);
        push_byte("c", 1'b0);
        set_budget(1'b1, 16'd2);
        push_byte("d", 1'b0);
        set_budget(1'b0, 16'd2);
        push_byte("e", 1'b1);
        push_byte("z", 1'b1);

        // Random strings under a range of budget settings.
        random_beats = 0;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0:       set_budget(1'b1, 16'($urandom_range(0, 24)));
                1:       set_budget(1'b0, 16'd0);
                2:       set_budget(1'b0, 16'($urandom));
                3:       set_budget(1'b1, 16'hFFFF);
                4:       set_budget(1'b1, 16'($urandom_range(8, 60)));
                default: set_budget(1'b1, DEFAULT_CAP);
            endcase
            if (ph == 2) begin
                // Receiver goes away while a long run of text keeps coming:
                // the block fills up and has to stall its input.
                push_ctrl(ACT_HOLD);
                for (int i = 0; i < 30; i++) begin
                    push_byte(8'($urandom_range(32, 126)), i == 29);
                end
            end
            while (random_beats < (ph + 1) * PHASE_BEATS) begin
                push_string($urandom_range(1, 24));
                if ($urandom_range(0, 5) == 0) begin
                    push_ctrl(ACT_DRAIN);   // sender pauses until everything is out
                end
            end
        end
        push_ctrl(ACT_DRAIN);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (run_done === 1'b1);
        $display("Escaped %0d input beats (%0d strings) into %0d checked output bytes.",
                 beats_taken, strings_taken, bytes_checked);
        $display("%0d truncation markers, %0d register writes.", markers_seen, reg_writes);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
